/* src/pbdc_pkg.sv */
// ----------------------------------------------------------------------------
// pbdc_pkg: shared types and constants of the PCM bit-depth converter
// Width codes, register indexes, full-scale helpers and inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package pbdc_pkg;

   localparam int SAMPLE_W = 32;
   localparam int MAG_W    = 31;

   // sample width codes
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_24 = 2'd2;
   localparam logic [1:0] WIDTH_32 = 2'd3;

   // register indexes
   localparam logic [1:0] REG_IN_WIDTH  = 2'd0;
   localparam logic [1:0] REG_OUT_WIDTH = 2'd1;
   localparam logic [1:0] REG_CHANNELS  = 2'd2;

   localparam logic [1:0] CH_MONO = 2'd1;

   localparam logic [1:0] RST_IN_WIDTH  = WIDTH_16;
   localparam logic [1:0] RST_OUT_WIDTH = WIDTH_16;
   localparam logic [1:0] RST_CHANNELS  = 2'd2;

   localparam logic [SAMPLE_W-1:0] OFFSET_8 = 32'h0000_0080;

   typedef struct packed {
      logic s1_en;   // decode stage loads
      logic s2_en;   // output stage loads
   } pipe_ctl_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] code;
      logic                sat;
   } lane_res_type;

   function automatic logic [SAMPLE_W-1:0] width_mask(input logic [1:0] w);
      logic [SAMPLE_W-1:0] m;
      case (w)
         WIDTH_8:  m = 32'h0000_00FF;
         WIDTH_16: m = 32'h0000_FFFF;
         WIDTH_24: m = 32'h00FF_FFFF;
         default:  m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

   function automatic logic [SAMPLE_W-1:0] full_scale(input logic [1:0] w);
      return width_mask(w) >> 1;
   endfunction

endpackage

`default_nettype wire

/* src/pcm_bit_depth_converter.sv */
// An accepted req word passes the decode registers, then the output registers, to its rsp word.
// Throughput: 1 frame per cycle; both channels run in their own lane.
// The two-stage pipeline stalls only when the rsp side holds back.
// Reset: synchronous, active high; clears the pipeline valids and loads
// in_width=16 bit, out_width=16 bit, channels=stereo.
// ----------------------------------------------------------------------------
// pcm_bit_depth_converter: integer PCM bit-depth conversion
// Converts one mono or stereo frame per word between 8/16/24/32-bit PCM.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_bit_depth_converter
   import pbdc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,   // [31:0] in_left, [63:32] in_right
   input  wire logic         req_tlast,   // block_end

   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,   // [31:0] out_left, [63:32] out_right
   output logic [1:0]        rsp_tuser,   // [0] sat_left, [1] sat_right
   output logic              rsp_tlast,   // last_out

   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [1:0]   csr_data
);

   logic [1:0] in_width_ff, in_width_in;
   logic [1:0] out_width_ff, out_width_in;
   logic [1:0] channels_ff, channels_in;

   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic last1_ff, last1_in;

   pipe_ctl_type ctl;
   lane_res_type res_left;
   lane_res_type res_right;

   assign csr_ready = 1'b1;

   always_comb begin
      in_width_in  = in_width_ff;
      out_width_in = out_width_ff;
      channels_in  = channels_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_IN_WIDTH:  in_width_in  = csr_data;
            REG_OUT_WIDTH: out_width_in = csr_data;
            REG_CHANNELS:  channels_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      ctl.s2_en  = ~v2_ff | rsp_tready;
      ctl.s1_en  = ~v1_ff | ctl.s2_en;
      req_tready = ctl.s1_en;
      v1_in      = ctl.s1_en ? req_tvalid : v1_ff;
      v2_in      = ctl.s2_en ? v1_ff : v2_ff;
      last1_in   = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff  <= RST_IN_WIDTH;
         out_width_ff <= RST_OUT_WIDTH;
         channels_ff  <= RST_CHANNELS;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
      end else begin
         in_width_ff  <= in_width_in;
         out_width_ff <= out_width_in;
         channels_ff  <= channels_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s1_en) begin
         last1_ff <= last1_in;
      end
   end

   pbdc_lane u_lane_left (
      .clock     (clock),
      .ctl       (ctl),
      .in_width  (in_width_ff),
      .out_width (out_width_ff),
      .raw       (req_tdata[31:0]),
      .res       (res_left)
   );

   pbdc_lane u_lane_right (
      .clock     (clock),
      .ctl       (ctl),
      .in_width  (in_width_ff),
      .out_width (out_width_ff),
      .raw       (req_tdata[63:32]),
      .res       (res_right)
   );

   pbdc_merge u_merge (
      .clock    (clock),
      .ctl      (ctl),
      .channels (channels_ff),
      .left     (res_left),
      .right    (res_right),
      .last     (last1_ff),
      .data     (rsp_tdata),
      .flags    (rsp_tuser),
      .last_out (rsp_tlast)
   );

   assign rsp_tvalid = v2_ff;

endmodule

`default_nettype wire

/* src/pbdc_lane.sv */
// ----------------------------------------------------------------------------
// pbdc_lane: one channel of the converter
// Decodes the raw container to sign and magnitude (registered), then scales
// by (2^b-1)/(2^k-1) exactly and re-encodes at the output width.
// ----------------------------------------------------------------------------
`default_nettype none

module pbdc_lane
   import pbdc_pkg::*;
(
   input  wire logic                clock,
   input  wire pipe_ctl_type        ctl,
   input  wire logic [1:0]          in_width,
   input  wire logic [1:0]          out_width,
   input  wire logic [SAMPLE_W-1:0] raw,
   output lane_res_type             res
);

   logic [SAMPLE_W-1:0] r;
   logic [SAMPLE_W-1:0] sign_bit;
   logic [SAMPLE_W-1:0] mag;
   logic                neg;
   logic                sat;

   logic [MAG_W-1:0] mag_ff, mag_in;
   logic             neg_ff, neg_in;
   logic             sat_ff, sat_in;

   // ---- decode ----
   always_comb begin
      r        = raw & width_mask(in_width);
      sign_bit = full_scale(in_width) + 32'd1;
      if (in_width == WIDTH_8) begin
         neg = (r < OFFSET_8);
         mag = neg ? (OFFSET_8 - r) : (r - OFFSET_8);
      end else begin
         neg = |(r & sign_bit);
         mag = neg ? ((width_mask(in_width) - r) + 32'd1) : r;
      end
      // only the most negative code lands above full scale
      sat    = (mag > full_scale(in_width));
      mag_in = mag[MAG_W-1:0];
      neg_in = neg;
      sat_in = sat;
   end

   always_ff @(posedge clock) begin
      if (ctl.s1_en) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
         sat_ff <= sat_in;
      end
   end

   // ---- scale ----
   // mag/(2^k-1) is the binary fraction 0.mag mag mag ... (period k).
   // q = floor(X*2^b - X): the first b bits, less one when the k bits that
   // follow them compare below mag.
   logic [63:0]          pat;
   logic [63:0]          shifted;
   logic [MAG_W-1:0]     ipart;
   logic [MAG_W-1:0]     gbits;
   logic                 lt;
   logic [MAG_W-1:0]     q;
   logic [SAMPLE_W-1:0]  code;
   logic [SAMPLE_W-1:0]  fs_out;

   always_comb begin
      case (in_width)
         WIDTH_8:  pat = {{9{mag_ff[6:0]}}, 1'b0};
         WIDTH_16: pat = {{4{mag_ff[14:0]}}, mag_ff[14:11]};
         WIDTH_24: pat = {{2{mag_ff[22:0]}}, mag_ff[22:5]};
         default:  pat = {{2{mag_ff[30:0]}}, mag_ff[30:29]};
      endcase

      case (out_width)
         WIDTH_8: begin
            ipart   = {24'd0, pat[63:57]};
            shifted = pat << 7;
         end
         WIDTH_16: begin
            ipart   = {16'd0, pat[63:49]};
            shifted = pat << 15;
         end
         WIDTH_24: begin
            ipart   = {8'd0, pat[63:41]};
            shifted = pat << 23;
         end
         default: begin
            ipart   = pat[63:33];
            shifted = pat << 31;
         end
      endcase

      case (in_width)
         WIDTH_8:  gbits = {24'd0, shifted[63:57]};
         WIDTH_16: gbits = {16'd0, shifted[63:49]};
         WIDTH_24: gbits = {8'd0, shifted[63:41]};
         default:  gbits = shifted[63:33];
      endcase

      lt = (gbits < mag_ff);

      fs_out = full_scale(out_width);
      if (sat_ff) begin
         q = fs_out[MAG_W-1:0] - 31'd1;
      end else begin
         q = ipart - {30'd0, lt};
      end

      code = neg_ff ? (32'd0 - {1'b0, q}) : {1'b0, q};
      if (out_width == WIDTH_8) begin
         code = code + OFFSET_8;
      end

      res.code = code & width_mask(out_width);
      res.sat  = sat_ff;
   end

endmodule

`default_nettype wire

/* src/pbdc_merge.sv */
// ----------------------------------------------------------------------------
// pbdc_merge: output stage
// Combines the two lane results into one response word and holds it.
// ----------------------------------------------------------------------------
`default_nettype none

module pbdc_merge
   import pbdc_pkg::*;
(
   input  wire logic                  clock,
   input  wire pipe_ctl_type          ctl,
   input  wire logic [1:0]            channels,
   input  wire lane_res_type          left,
   input  wire lane_res_type          right,
   input  wire logic                  last,
   output logic [2*SAMPLE_W-1:0]      data,
   output logic [1:0]                 flags,
   output logic                       last_out
);

   logic [2*SAMPLE_W-1:0] data_ff, data_in;
   logic [1:0]            flags_ff, flags_in;
   logic                  last_ff, last_in;
   logic                  mono;

   always_comb begin
      mono     = (channels == CH_MONO);
      data_in  = {mono ? {SAMPLE_W{1'b0}} : right.code, left.code};
      flags_in = {right.sat & ~mono, left.sat};
      last_in  = last;
   end

   always_ff @(posedge clock) begin
      if (ctl.s2_en) begin
         data_ff  <= data_in;
         flags_ff <= flags_in;
         last_ff  <= last_in;
      end
   end

   assign data     = data_ff;
   assign flags    = flags_ff;
   assign last_out = last_ff;

endmodule

`default_nettype wire
